FILE: rtl/core/etr_pkg.sv
// Shared constants, command codes and the day-of-year table for the epoch timekeeper.
package etr_pkg;

  localparam int unsigned DayBitsDefault = 9;

  localparam logic [8:0]  RebaseLimitReset = 9'd400;
  localparam logic [31:0] UnsetEpochReset  = 32'd1767225600;

  localparam logic [16:0] SecsPerDay  = 17'd86400;
  localparam logic [16:0] SecsPerHour = 17'd3600;
  localparam logic [16:0] SecsPerMin  = 17'd60;
  localparam logic [16:0] DaysPerYear = 17'd365;

  // Reciprocals scaled by 2^32 and rounded down, so a quotient estimate is never too large
  // and falls short by at most one.
  localparam logic [16:0] RecipDay  = 17'd49710;
  localparam logic [31:0] RecipHour = 32'd1193046;
  localparam logic [31:0] RecipMin  = 32'd71582788;

  // Days from 0000-03-01 to 1970-01-01 subtracted from the start of era 4 or era 5.
  localparam logic [31:0] EraBase4 = 32'(4 * 146097) - 32'(719468);
  localparam logic [31:0] EraBase5 = 32'(5 * 146097) - 32'(719468);

  localparam logic [1:0] CmdTick     = 2'd0;
  localparam logic [1:0] CmdSetEpoch = 2'd1;
  localparam logic [1:0] CmdSetCivil = 2'd2;
  localparam logic [1:0] CmdRead     = 2'd3;

  localparam logic RegRebaseLimit = 1'b0;
  localparam logic RegUnsetEpoch  = 1'b1;

  // Days before the first of a month, counted from March: (153 * mp + 2) / 5.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    begin
      case (mp)
        4'd0:    r = 9'd0;
        4'd1:    r = 9'd31;
        4'd2:    r = 9'd61;
        4'd3:    r = 9'd92;
        4'd4:    r = 9'd122;
        4'd5:    r = 9'd153;
        4'd6:    r = 9'd184;
        4'd7:    r = 9'd214;
        4'd8:    r = 9'd245;
        4'd9:    r = 9'd275;
        4'd10:   r = 9'd306;
        4'd11:   r = 9'd337;
        4'd12:   r = 9'd367;
        default: r = 9'd0;
      endcase
      return r;
    end
  endfunction

endpackage

FILE: rtl/core/epoch_timekeeper_with_rebase_unit.sv
// Epoch timekeeper: midnight base epoch, day and h:m:s counters, civil date conversion.
// One transaction at a time; the result becomes valid as the block returns to idle and
// can accept again, and a stalled output register holds it in its finish state meanwhile.
// The shared 32x17 multiplier serves every step; each split by a day, an hour or a minute
// is a reciprocal estimate, a multiply back and at most one correction step.
// Reset clears the clock to the unset state and loads the register reset values.
module epoch_timekeeper_with_rebase_unit #(
  parameter int unsigned DAY_BITS = etr_pkg::DayBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] epoch_in_i,
  input  logic [6:0]  year_offset_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_of_month_i,
  input  logic [4:0]  hour_i,
  input  logic [5:0]  minute_i,
  input  logic [5:0]  second_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] epoch_out_o,
  output logic        time_is_set_o,
  output logic        rebased_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);
  import etr_pkg::*;

  localparam int unsigned CmpW = (DAY_BITS > 9) ? DAY_BITS : 9;

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CIV1 = 4'd1;
  localparam logic [3:0] S_CIV2 = 4'd2;
  localparam logic [3:0] S_CIV3 = 4'd3;
  localparam logic [3:0] S_CIV4 = 4'd4;
  localparam logic [3:0] S_CIV5 = 4'd5;
  localparam logic [3:0] S_CIV6 = 4'd6;
  localparam logic [3:0] S_DV1  = 4'd7;
  localparam logic [3:0] S_DV2  = 4'd8;
  localparam logic [3:0] S_DV3  = 4'd9;
  localparam logic [3:0] S_DV4  = 4'd10;
  localparam logic [3:0] S_RD1  = 4'd11;
  localparam logic [3:0] S_RD2  = 4'd12;
  localparam logic [3:0] S_RD3  = 4'd13;
  localparam logic [3:0] S_RD4  = 4'd14;
  localparam logic [3:0] S_FIN  = 4'd15;

  // Divider phases: seconds of day, then hours, then minutes.
  localparam logic [1:0] P_DAY  = 2'd0;
  localparam logic [1:0] P_HOUR = 2'd1;
  localparam logic [1:0] P_MIN  = 2'd2;

  logic [3:0]          state_q, state_d;
  logic [8:0]          limit_q, limit_d;
  logic [31:0]         unset_q, unset_d;
  logic [31:0]         base_q, base_d;
  logic [DAY_BITS-1:0] day_q, day_d;
  logic [4:0]          hour_q, hour_d;
  logic [5:0]          min_q, min_d;
  logic [5:0]          sec_q, sec_d;
  logic                out_valid_q, out_valid_d;
  logic [31:0]         res_epoch_q, res_epoch_d;
  logic                res_rebased_q, res_rebased_d;
  logic                res_set_q, res_set_d;

  // Working registers of the shared datapath.
  logic [31:0] acc_q, acc_d;
  logic [48:0] mul_q;
  logic [8:0]  yoe_q, yoe_d;
  logic [4:0]  hh_q, hh_d;
  logic [5:0]  mm_q, mm_d;
  logic [5:0]  ss_q, ss_d;
  logic [31:0] epoch_q, epoch_d;
  logic [16:0] quo_q, quo_d;
  logic [1:0]  phase_q, phase_d;
  logic [31:0] pend_epoch_q, pend_epoch_d;
  logic        pend_rebased_q, pend_rebased_d;

  // Shared multiplier operands.
  logic [31:0] mul_a;
  logic [16:0] mul_b;
  logic [48:0] mul_full;

  // Civil date front end.
  logic        le_feb;
  logic [11:0] civ_y;
  logic        era5;
  logic [8:0]  civ_yoe;
  logic [3:0]  civ_mp;
  logic [1:0]  cent;
  logic [10:0] doy;
  logic [31:0] civ_acc;

  // Divisor of the current phase.
  logic [16:0] divisor;

  // Read finish.
  logic        rd_set;
  logic [31:0] rd_base;
  logic        rd_fold;
  logic [31:0] civ_total;

  assign mul_full = 49'(mul_a) * 49'(mul_b);

  // Year and era arithmetic; only eras 4 and 5 are reachable from year 2000 on.
  always_comb begin
    le_feb  = (month_i <= 4'd2);
    civ_y   = 12'd2000 + 12'(year_offset_i) - 12'(le_feb);
    era5    = (civ_y >= 12'd2000);
    civ_yoe = era5 ? 9'(civ_y - 12'd2000) : 9'(civ_y - 12'd1600);
    civ_mp  = (month_i > 4'd2) ? (month_i - 4'd3) : (month_i + 4'd9);
    if (civ_yoe >= 9'd300) begin
      cent = 2'd3;
    end else if (civ_yoe >= 9'd200) begin
      cent = 2'd2;
    end else if (civ_yoe >= 9'd100) begin
      cent = 2'd1;
    end else begin
      cent = 2'd0;
    end
    // The day of year goes to minus one for day zero of March.
    doy     = {2'b00, month_start(civ_mp)} + {6'd0, day_of_month_i} - 11'd1;
    civ_acc = (era5 ? EraBase5 : EraBase4) + 32'(civ_yoe >> 2) - 32'(cent)
              + {{21{doy[10]}}, doy};
  end

  always_comb begin
    case (phase_q)
      P_DAY:   divisor = SecsPerDay;
      P_HOUR:  divisor = SecsPerHour;
      default: divisor = SecsPerMin;
    endcase
  end

  always_comb begin
    rd_set    = (base_q != 32'd0);
    rd_base   = rd_set ? base_q : unset_q;
    rd_fold   = rd_set && (CmpW'(day_q) >= CmpW'(limit_q));
    civ_total = acc_q + mul_q[31:0] + 32'(ss_q);
  end

  always_comb begin
    state_d        = state_q;
    limit_d        = limit_q;
    unset_d        = unset_q;
    base_d         = base_q;
    day_d          = day_q;
    hour_d         = hour_q;
    min_d          = min_q;
    sec_d          = sec_q;
    out_valid_d    = out_valid_q;
    res_epoch_d    = res_epoch_q;
    res_rebased_d  = res_rebased_q;
    res_set_d      = res_set_q;
    acc_d          = acc_q;
    yoe_d          = yoe_q;
    hh_d           = hh_q;
    mm_d           = mm_q;
    ss_d           = ss_q;
    epoch_d        = epoch_q;
    quo_d          = quo_q;
    phase_d        = phase_q;
    pend_epoch_d   = pend_epoch_q;
    pend_rebased_d = pend_rebased_q;
    mul_a          = 32'd0;
    mul_b          = 17'd0;

    if (cfg_we_i) begin
      if (cfg_index_i == RegRebaseLimit) begin
        limit_d = cfg_wdata_i[8:0];
      end else begin
        unset_d = cfg_wdata_i;
      end
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          // The previous result may still wait in the output register, so the new one
          // is built in the pending registers and moved over at the end.
          pend_epoch_d   = 32'd0;
          pend_rebased_d = 1'b0;
          case (command_i)
            CmdTick: begin
              if (sec_q >= 6'd59) begin
                sec_d = 6'd0;
                if (min_q >= 6'd59) begin
                  min_d = 6'd0;
                  if (hour_q >= 5'd23) begin
                    hour_d = 5'd0;
                    day_d  = day_q + DAY_BITS'(1);
                  end else begin
                    hour_d = hour_q + 5'd1;
                  end
                end else begin
                  min_d = min_q + 6'd1;
                end
              end else begin
                sec_d = sec_q + 6'd1;
              end
              state_d = S_FIN;
            end
            CmdSetEpoch: begin
              epoch_d = epoch_in_i;
              acc_d   = epoch_in_i;
              phase_d = P_DAY;
              state_d = S_DV1;
            end
            CmdSetCivil: begin
              acc_d   = civ_acc;
              yoe_d   = civ_yoe;
              hh_d    = hour_i;
              mm_d    = minute_i;
              ss_d    = second_i;
              state_d = S_CIV1;
            end
            default: begin
              state_d = S_RD1;
            end
          endcase
        end
      end
      S_CIV1: begin
        mul_a   = 32'(yoe_q);
        mul_b   = DaysPerYear;
        state_d = S_CIV2;
      end
      S_CIV2: begin
        acc_d   = acc_q + mul_q[31:0];
        state_d = S_CIV3;
      end
      S_CIV3: begin
        mul_a   = acc_q;
        mul_b   = SecsPerDay;
        state_d = S_CIV4;
      end
      S_CIV4: begin
        acc_d   = mul_q[31:0];
        mul_a   = 32'(hh_q);
        mul_b   = SecsPerHour;
        state_d = S_CIV5;
      end
      S_CIV5: begin
        acc_d   = acc_q + mul_q[31:0];
        mul_a   = 32'(mm_q);
        mul_b   = SecsPerMin;
        state_d = S_CIV6;
      end
      S_CIV6: begin
        epoch_d = civ_total;
        acc_d   = civ_total;
        phase_d = P_DAY;
        state_d = S_DV1;
      end
      S_DV1: begin
        // Quotient estimate: dividend times the scaled reciprocal, upper bits kept.
        case (phase_q)
          P_DAY: begin
            mul_a = acc_q;
            mul_b = RecipDay;
          end
          P_HOUR: begin
            mul_a = RecipHour;
            mul_b = acc_q[16:0];
          end
          default: begin
            mul_a = RecipMin;
            mul_b = acc_q[16:0];
          end
        endcase
        state_d = S_DV2;
      end
      S_DV2: begin
        quo_d   = mul_q[48:32];
        mul_a   = 32'(mul_q[48:32]);
        mul_b   = divisor;
        state_d = S_DV3;
      end
      S_DV3: begin
        acc_d   = acc_q - mul_q[31:0];
        state_d = S_DV4;
      end
      S_DV4: begin
        if (acc_q >= 32'(divisor)) begin
          acc_d = acc_q - 32'(divisor);
          quo_d = quo_q + 17'd1;
        end else begin
          case (phase_q)
            P_DAY: begin
              // acc_q now holds the seconds of day.
              base_d  = epoch_q - acc_q;
              phase_d = P_HOUR;
              state_d = S_DV1;
            end
            P_HOUR: begin
              hour_d  = quo_q[4:0];
              phase_d = P_MIN;
              state_d = S_DV1;
            end
            default: begin
              min_d   = quo_q[5:0];
              sec_d   = acc_q[5:0];
              day_d   = '0;
              state_d = S_FIN;
            end
          endcase
        end
      end
      S_RD1: begin
        mul_a   = 32'(hour_q);
        mul_b   = SecsPerHour;
        state_d = S_RD2;
      end
      S_RD2: begin
        acc_d   = mul_q[31:0] + 32'(sec_q);
        mul_a   = 32'(min_q);
        mul_b   = SecsPerMin;
        state_d = S_RD3;
      end
      S_RD3: begin
        acc_d   = acc_q + mul_q[31:0];
        mul_a   = 32'(day_q);
        mul_b   = SecsPerDay;
        state_d = S_RD4;
      end
      S_RD4: begin
        // mul_q holds the day count in seconds, acc_q the seconds of day.
        pend_epoch_d = rd_base + mul_q[31:0] + acc_q;
        if (rd_fold) begin
          base_d         = rd_base + mul_q[31:0];
          day_d          = '0;
          pend_rebased_d = 1'b1;
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d   = 1'b1;
          res_epoch_d   = pend_epoch_q;
          res_rebased_d = pend_rebased_q;
          res_set_d     = (base_q != 32'd0);
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= RebaseLimitReset;
      unset_q     <= UnsetEpochReset;
      base_q      <= 32'd0;
      day_q       <= '0;
      hour_q      <= 5'd0;
      min_q       <= 6'd0;
      sec_q       <= 6'd0;
      out_valid_q <= 1'b0;
      phase_q     <= P_DAY;
    end else begin
      state_q     <= state_d;
      limit_q     <= limit_d;
      unset_q     <= unset_d;
      base_q      <= base_d;
      day_q       <= day_d;
      hour_q      <= hour_d;
      min_q       <= min_d;
      sec_q       <= sec_d;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_epoch_q    <= res_epoch_d;
    res_rebased_q  <= res_rebased_d;
    res_set_q      <= res_set_d;
    acc_q          <= acc_d;
    mul_q          <= mul_full;
    yoe_q          <= yoe_d;
    hh_q           <= hh_d;
    mm_q           <= mm_d;
    ss_q           <= ss_d;
    epoch_q        <= epoch_d;
    quo_q          <= quo_d;
    pend_epoch_q   <= pend_epoch_d;
    pend_rebased_q <= pend_rebased_d;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign epoch_out_o   = res_epoch_q;
  assign time_is_set_o = res_set_q;
  assign rebased_o     = res_rebased_q;

endmodule

FILE: sim/epoch_timekeeper_with_rebase_unit_tb.sv
// Self-checking testbench for the epoch timekeeper with day rebase.
`timescale 1ns / 100ps

module epoch_timekeeper_with_rebase_unit_tb;
  import etr_pkg::*;

  // The block holds one transaction at a time; set civil is the slowest.
  localparam int unsigned SettleCycles = 100;
  localparam int unsigned CycleLimit   = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  command_i = CmdTick;
  logic [31:0] epoch_in_i = '0;
  logic [6:0]  year_offset_i = '0;
  logic [3:0]  month_i = 4'd1;
  logic [4:0]  day_of_month_i = 5'd1;
  logic [4:0]  hour_i = '0;
  logic [5:0]  minute_i = '0;
  logic [5:0]  second_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] epoch_out_o;
  logic        time_is_set_o;
  logic        rebased_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = RegRebaseLimit;
  logic [31:0] cfg_wdata_i = '0;

  epoch_timekeeper_with_rebase_unit DUT (.*);

  always #10 clk_i = ~clk_i;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] epoch_in;
    logic [6:0]  year_offset;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } clock_cmd_t;

  typedef struct packed {
    logic [31:0] epoch_out;
    logic        time_is_set;
    logic        rebased;
  } clock_reading_t;

  // Predicted copy of the block's clock state and registers.
  logic [8:0]  rebase_limit;
  logic [31:0] unset_epoch;
  logic [31:0] base_epoch;
  logic [8:0]  day_count;
  logic [4:0]  hour_count;
  logic [5:0]  minute_count;
  logic [5:0]  second_count;

  clock_reading_t expected_readings[$];
  int unsigned    error_count = 0;
  int unsigned    cycle_count = 0;
  bit             idle_enable = 1'b1;
  bit             hold_off    = 1'b0;

  // Midnight base plus h:m:s; the day counter starts over.
  function automatic void load_epoch(input logic [31:0] epoch);
    logic [31:0] sod;
    sod          = epoch % 32'd86400;
    day_count    = '0;
    hour_count   = 5'(sod / 32'd3600);
    minute_count = 6'((sod % 32'd3600) / 32'd60);
    second_count = 6'(sod % 32'd60);
    base_epoch   = epoch - sod;
  endfunction

  // Days-from-civil for years 2000 onward; out-of-range fields go through unchanged.
  function automatic logic [31:0] civil_to_epoch(input clock_cmd_t c);
    longint y, era, yoe, mp, doy, doe, days, t;
    y    = 2000 + c.year_offset - ((c.month <= 2) ? 1 : 0);
    era  = y / 400;
    yoe  = y - era * 400;
    mp   = longint'(c.month) + ((c.month > 2) ? -3 : 9);
    doy  = (153 * mp + 2) / 5 + c.day_of_month - 1;
    doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days = era * 146097 + doe - 719468;
    t    = days * 86400 + c.hour * 3600 + c.minute * 60 + c.second;
    return t[31:0];
  endfunction

  function automatic clock_reading_t advance_clock(input clock_cmd_t c);
    clock_reading_t r;
    logic [31:0]    base, sod;
    r = '0;
    case (c.command)
      CmdTick: begin
        second_count++;
        if (second_count >= 60) begin
          second_count = 0;
          minute_count++;
          if (minute_count >= 60) begin
            minute_count = 0;
            hour_count++;
            if (hour_count >= 24) begin
              hour_count = 0;
              day_count++;
            end
          end
        end
      end
      CmdSetEpoch: load_epoch(c.epoch_in);
      CmdSetCivil: load_epoch(civil_to_epoch(c));
      default: begin
        base = (base_epoch != 0) ? base_epoch : unset_epoch;
        sod  = hour_count * 32'd3600 + minute_count * 32'd60 + second_count;
        if (base_epoch != 0 && day_count >= rebase_limit) begin
          base       = base + day_count * 32'd86400;
          base_epoch = base;
          day_count  = '0;
          r.rebased  = 1'b1;
          r.epoch_out = base + sod;
        end else begin
          r.epoch_out = base + day_count * 32'd86400 + sod;
        end
      end
    endcase
    r.time_is_set = (base_epoch != 0);
    return r;
  endfunction

  // Valid drops only for an idle gap; otherwise the next offer follows at once.
  task automatic idle_burst();
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
  endtask

  // Offers one transaction and predicts its reading once it is accepted.
  task automatic send_cmd(input clock_cmd_t c);
    idle_burst();
    in_valid_i     <= 1'b1;
    command_i      <= c.command;
    epoch_in_i     <= c.epoch_in;
    year_offset_i  <= c.year_offset;
    month_i        <= c.month;
    day_of_month_i <= c.day_of_month;
    hour_i         <= c.hour;
    minute_i       <= c.minute;
    second_i       <= c.second;
    do @(posedge clk_i); while (in_stall_o);
    expected_readings.push_back(advance_clock(c));
    @(negedge clk_i);
  endtask

  // Waits for every reading, then lets the block settle before a register write.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_readings.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic index, input logic [31:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (index == RegRebaseLimit) rebase_limit = value[8:0];
    else unset_epoch = value;
  endtask

  function automatic clock_cmd_t mk_cmd(input logic [1:0] op);
    clock_cmd_t c;
    c = '0;
    c.command = op;
    c.month = 4'd1;
    c.day_of_month = 5'd1;
    return c;
  endfunction

  function automatic clock_cmd_t rand_cmd(input logic [1:0] op, input bit wild);
    clock_cmd_t c;
    c.command      = op;
    c.epoch_in     = $urandom;
    c.year_offset  = wild ? 7'($urandom) : 7'($urandom_range(0, 99));
    c.month        = wild ? 4'($urandom) : 4'($urandom_range(1, 12));
    c.day_of_month = wild ? 5'($urandom) : 5'($urandom_range(1, 31));
    c.hour         = wild ? 5'($urandom) : 5'($urandom_range(0, 23));
    c.minute       = wild ? 6'($urandom) : 6'($urandom_range(0, 59));
    c.second       = wild ? 6'($urandom) : 6'($urandom_range(0, 59));
    return c;
  endfunction

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_cmd(mk_cmd(CmdTick));
  endtask

  // Reads before any set, then the unset register at its extremes.
  task automatic test_unset_reads();
    send_cmd(mk_cmd(CmdRead));
    send_ticks(2);
    send_cmd(mk_cmd(CmdRead));
    write_reg(RegUnsetEpoch, 32'hFFFF_FFFF);
    send_cmd(mk_cmd(CmdRead));
    write_reg(RegUnsetEpoch, 32'h0000_0000);
    send_cmd(mk_cmd(CmdRead));
  endtask

  // Epoch loads at the edges, including one below a day that leaves the clock unset.
  task automatic test_set_epoch();
    clock_cmd_t c;
    c = mk_cmd(CmdSetEpoch);
    c.epoch_in = 32'd86399;       send_cmd(c); send_cmd(mk_cmd(CmdRead));
    c.epoch_in = 32'hFFFF_FFFF;   send_cmd(c); send_cmd(mk_cmd(CmdRead));
    // One second before midnight, so a tick rolls the day over.
    c.epoch_in = 32'd86400 * 5 + 32'd86399; send_cmd(c);
    send_ticks(1);
    send_cmd(mk_cmd(CmdRead));
  endtask

  // Civil dates at the field extremes and with out-of-range fields.
  task automatic test_set_civil();
    clock_cmd_t c;
    c = mk_cmd(CmdSetCivil);
    send_cmd(c); send_cmd(mk_cmd(CmdRead));
    c.year_offset = 7'd99; c.month = 4'd12; c.day_of_month = 5'd31;
    c.hour = 5'd23; c.minute = 6'd59; c.second = 6'd59;
    send_cmd(c); send_cmd(mk_cmd(CmdRead));
    c.year_offset = 7'd127; c.month = 4'd15; c.day_of_month = 5'd31;
    c.hour = 5'd31; c.minute = 6'd63; c.second = 6'd63;
    send_cmd(c); send_cmd(mk_cmd(CmdRead));
    c = mk_cmd(CmdSetCivil);
    c.month = 4'd0; c.day_of_month = 5'd0;
    send_cmd(c); send_cmd(mk_cmd(CmdRead));
  endtask

  // Folding at the rebase limit, including limit zero and a base near the top of the range.
  task automatic test_rebase();
    clock_cmd_t c;
    write_reg(RegRebaseLimit, 32'd1);
    c = mk_cmd(CmdSetEpoch);
    c.epoch_in = 32'd86400 * 2 + 32'd86399;
    send_cmd(c);
    send_ticks(1);
    send_cmd(mk_cmd(CmdRead));
    write_reg(RegRebaseLimit, 32'd0);
    send_cmd(mk_cmd(CmdRead));
    // One second before the last midnight below 2^32, so a tick reaches that day.
    write_reg(RegRebaseLimit, 32'd1);
    c.epoch_in = 32'd86400 * 49709 + 32'd86399;
    send_cmd(c);
    send_ticks(1);
    send_cmd(mk_cmd(CmdRead));
    c.epoch_in = 32'd86400 * 4 + 32'd86399;
    send_cmd(c);
    write_reg(RegRebaseLimit, 32'd511);
    send_ticks(1);
    send_cmd(mk_cmd(CmdRead));
  endtask

  // Random traffic: mostly ticks and reads on a set clock, sets with wild fields now and then.
  task automatic test_random(input int unsigned n);
    int unsigned k;
    for (int unsigned i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (i == n / 2) hold_off = 1'b1;
      if (i > n * 9 / 10) idle_enable = 1'b0;
      if (k < 45) send_cmd(mk_cmd(CmdTick));
      else if (k < 75) send_cmd(mk_cmd(CmdRead));
      else if (k < 85) send_cmd(rand_cmd(CmdSetEpoch, 1'b0));
      else send_cmd(rand_cmd(CmdSetCivil, k >= 95));
      if (i % 300 == 150) begin
        write_reg(RegRebaseLimit, 32'($urandom_range(0, 3)));
        write_reg(RegUnsetEpoch, $urandom);
      end
    end
  endtask

  // Receiver stalls: random bursts, one long hold-off, none near the end.
  initial begin
    int unsigned held;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        held = 0;
        while (held < 300) begin
          @(negedge clk_i);
          held++;
        end
        hold_off = 1'b0;
        out_stall_i <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compares each accepted reading with the oldest prediction.
  always @(posedge clk_i) begin
    clock_reading_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected transaction: epoch_out %h", epoch_out_o);
        error_count++;
      end else begin
        exp_r = expected_readings.pop_front();
        if (epoch_out_o !== exp_r.epoch_out) begin
          $error("epoch_out expected %h actual %h", exp_r.epoch_out, epoch_out_o);
          error_count++;
        end
        if (time_is_set_o !== exp_r.time_is_set) begin
          $error("time_is_set expected %b actual %b", exp_r.time_is_set, time_is_set_o);
          error_count++;
        end
        if (rebased_o !== exp_r.rebased) begin
          $error("rebased expected %b actual %b", exp_r.rebased, rebased_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rebase_limit = RebaseLimitReset;
    unset_epoch  = UnsetEpochReset;
    base_epoch   = '0;
    day_count    = '0;
    hour_count   = '0;
    minute_count = '0;
    second_count = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_unset_reads();
    test_set_epoch();
    test_set_civil();
    test_rebase();
    test_random(1130);
    drain();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
